// ===== hdl/qsm_pkg.sv =====
// qsm_pkg: shared types and constants of the quadrature speed meter
// register indexes, direction codes, divider states, configuration bundle
// no dependencies
`default_nettype none

package qsm_pkg;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_PPR    = 2'd0,
    REG_WINDOW = 2'd1
  } qsm_reg_t;

  // reported direction codes
  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_CW   = 2'd1,
    DIR_CCW  = 2'd2
  } qsm_dir_t;

  // serial divider sequencer states
  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_SETUP,
    DIV_RUN,
    DIV_DONE
  } qsm_div_state_t;

  // configuration as seen by the datapath
  typedef struct packed {
    logic [15:0] ppr;
    logic [15:0] win;
  } qsm_cfg_t;

  localparam int unsigned CFG_W = 16;
  localparam int unsigned EDGE_OUT_W = 24;
  localparam int unsigned SPEED_W = 32;
  // denominator 4*ppr*win fits in 34 bits
  localparam int unsigned DEN_W = 34;
  // numerator scale 1000 * 2^16: multiply by 1000, then 16 zero bits
  localparam int unsigned SCALE_MUL = 1000;
  localparam int unsigned SCALE_MUL_W = 10;
  localparam int unsigned SCALE_SHIFT = 16;
  // ppr and window reset values
  localparam logic [15:0] PPR_RESET = 16'd408;
  localparam logic [15:0] WIN_RESET = 16'd500;

endpackage

`default_nettype wire

// ===== hdl/qsm_counter.sv =====
// qsm_counter: x4 quadrature edge decoder, saturating edge total, ms window timer
// depends on qsm_pkg
`default_nettype none

module qsm_counter #(
  parameter int COUNT_WIDTH = 24
) (
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        accept,
  input  wire                        pin_a,
  input  wire                        pin_b,
  input  wire                        ms_tick,
  input  wire qsm_pkg::qsm_cfg_t     cfg,
  output logic                       closes,
  output logic [COUNT_WIDTH-1:0]     snap
);

  logic                   last_a;
  logic                   last_b;
  logic [COUNT_WIDTH-1:0] edge_total;
  logic [15:0]            tick_counter;

  logic signed [1:0]      delta;
  logic [COUNT_WIDTH:0]   sum;
  logic [16:0]            tick_inc;
  logic [15:0]            win_eff;

  // edge contributions; both pins changing cancel out
  always_comb begin
    delta = 2'sd0;
    if ((pin_a != last_a) && (pin_b == last_b)) begin
      delta = (pin_a == pin_b) ? -2'sd1 : 2'sd1;
    end else if ((pin_b != last_b) && (pin_a == last_a)) begin
      delta = (pin_a == pin_b) ? 2'sd1 : -2'sd1;
    end
  end

  // saturating add of the contribution
  always_comb begin
    sum = {edge_total[COUNT_WIDTH-1], edge_total}
        + {{(COUNT_WIDTH-1){delta[1]}}, delta};
    if (sum[COUNT_WIDTH] != sum[COUNT_WIDTH-1]) begin
      snap = sum[COUNT_WIDTH] ? {1'b1, {(COUNT_WIDTH-1){1'b0}}}
                              : {1'b0, {(COUNT_WIDTH-1){1'b1}}};
    end else begin
      snap = sum[COUNT_WIDTH-1:0];
    end
  end

  // window close test, zero window behaves as one tick
  always_comb begin
    win_eff  = (cfg.win == 16'd0) ? 16'd1 : cfg.win;
    tick_inc = {1'b0, tick_counter} + 17'd1;
    closes   = ms_tick && (tick_inc >= {1'b0, win_eff});
  end

  // state update per accepted sample
  always_ff @(posedge clk) begin
    if (rst) begin
      last_a       <= 1'b0;
      last_b       <= 1'b0;
      edge_total   <= '0;
      tick_counter <= 16'd0;
    end else if (accept) begin
      last_a <= pin_a;
      last_b <= pin_b;
      if (closes) begin
        edge_total   <= '0;
        tick_counter <= 16'd0;
      end else begin
        edge_total <= snap;
        if (ms_tick) begin
          tick_counter <= tick_inc[15:0];
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/qsm_divider.sv =====
// qsm_divider: bit-serial restoring divider for the window speed plus result register
// depends on qsm_pkg
`default_nettype none

module qsm_divider #(
  parameter int COUNT_WIDTH = 24
) (
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        start,
  input  wire  [COUNT_WIDTH-1:0]     snap,
  input  wire qsm_pkg::qsm_cfg_t     cfg,
  input  wire                        out_stall,
  output logic                       busy,
  output logic                       out_valid,
  output logic signed [23:0]         edge_count,
  output logic [1:0]                 direction,
  output logic signed [31:0]         speed_q16
);

  localparam int MUL_W = COUNT_WIDTH + qsm_pkg::SCALE_MUL_W;
  localparam int NUM_W = MUL_W + qsm_pkg::SCALE_SHIFT;
  localparam int CNT_W = $clog2(NUM_W + 1);
  localparam int DW    = qsm_pkg::DEN_W;
  localparam int SW    = qsm_pkg::SPEED_W;

  qsm_pkg::qsm_div_state_t state;
  qsm_pkg::qsm_div_state_t state_next;

  logic                   neg;
  logic [COUNT_WIDTH-1:0] mag;
  logic [15:0]            ppr_eff;
  logic [15:0]            win_eff;
  logic [23:0]            shown;
  qsm_pkg::qsm_dir_t      dir;
  logic [NUM_W-1:0]       num;
  logic [DW-1:0]          den;
  logic [DW-1:0]          rem;
  logic [SW-1:0]          quot;
  logic                   big;
  logic [CNT_W-1:0]       steps;

  logic signed [32:0]     snap_ext;
  logic [DW:0]            trial;
  logic                   take;
  logic [SW-1:0]          speed_fin;
  logic                   load_out;

  // next state and handshake outputs
  always_comb begin
    state_next = state;
    load_out   = 1'b0;
    busy       = (state != qsm_pkg::DIV_IDLE);
    case (state)
      qsm_pkg::DIV_IDLE: begin
        if (start) begin
          state_next = qsm_pkg::DIV_SETUP;
        end
      end
      qsm_pkg::DIV_SETUP: begin
        state_next = qsm_pkg::DIV_RUN;
      end
      qsm_pkg::DIV_RUN: begin
        if (steps == CNT_W'(1)) begin
          state_next = qsm_pkg::DIV_DONE;
        end
      end
      qsm_pkg::DIV_DONE: begin
        if (!out_valid || !out_stall) begin
          load_out   = 1'b1;
          state_next = qsm_pkg::DIV_IDLE;
        end
      end
      default: begin
        state_next = qsm_pkg::DIV_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= qsm_pkg::DIV_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // one quotient bit per step
  always_comb begin
    trial = {rem, num[NUM_W-1]};
    take  = (trial >= {1'b0, den});
  end

  // sign and saturation of the quotient
  always_comb begin
    if (neg) begin
      if (big || (quot > 32'h8000_0000)) begin
        speed_fin = 32'h8000_0000;
      end else begin
        speed_fin = ~quot + 32'd1;
      end
    end else begin
      if (big || quot[SW-1]) begin
        speed_fin = 32'h7FFF_FFFF;
      end else begin
        speed_fin = quot;
      end
    end
  end

  assign snap_ext = {{(33 - COUNT_WIDTH){snap[COUNT_WIDTH-1]}}, snap};

  // snapshot capture and divider datapath
  always_ff @(posedge clk) begin
    case (state)
      qsm_pkg::DIV_IDLE: begin
        if (start) begin
          neg     <= snap[COUNT_WIDTH-1];
          mag     <= snap[COUNT_WIDTH-1] ? (~snap + COUNT_WIDTH'(1)) : snap;
          ppr_eff <= (cfg.ppr == 16'd0) ? 16'd1 : cfg.ppr;
          win_eff <= (cfg.win == 16'd0) ? 16'd1 : cfg.win;
          if (snap_ext > 33'sd8388607) begin
            shown <= 24'h7F_FFFF;
          end else if (snap_ext < -33'sd8388608) begin
            shown <= 24'h80_0000;
          end else begin
            shown <= snap_ext[23:0];
          end
          if (snap_ext > 33'sd0) begin
            dir <= qsm_pkg::DIR_CW;
          end else if (snap_ext < 33'sd0) begin
            dir <= qsm_pkg::DIR_CCW;
          end else begin
            dir <= qsm_pkg::DIR_NONE;
          end
        end
      end
      qsm_pkg::DIV_SETUP: begin
        num   <= {MUL_W'(mag) * MUL_W'(qsm_pkg::SCALE_MUL), {qsm_pkg::SCALE_SHIFT{1'b0}}};
        den   <= {32'(ppr_eff) * 32'(win_eff), 2'b00};
        rem   <= '0;
        quot  <= '0;
        big   <= 1'b0;
        steps <= CNT_W'(NUM_W);
      end
      qsm_pkg::DIV_RUN: begin
        num   <= {num[NUM_W-2:0], 1'b0};
        rem   <= take ? DW'(trial - {1'b0, den}) : trial[DW-1:0];
        quot  <= {quot[SW-2:0], take};
        big   <= big | quot[SW-1];
        steps <= steps - CNT_W'(1);
      end
      default: begin
      end
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      edge_count <= shown;
      direction  <= dir;
      speed_q16  <= speed_fin;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/quadrature_speed_meter.sv =====
// quadrature_speed_meter: x4 encoder decoder with windowed speed in Q16.16 rev/s
// result path: a window-closing sample passes through the divider setup, run and done states into the result register
// throughput: one sample per cycle; a closing sample waits while the divider holds the
// previous window, including while its result is stalled
// reset: synchronous, clears pins history, edge total, tick counter, divider and
// result valid; pulses_per_rev returns to 408 and window_ms to 500
`default_nettype none

module quadrature_speed_meter #(
  parameter int COUNT_WIDTH = 24
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  output logic                in_stall,
  input  wire                 pin_a,
  input  wire                 pin_b,
  input  wire                 ms_tick,
  output logic                out_valid,
  input  wire                 out_stall,
  output logic signed [23:0]  edge_count,
  output logic [1:0]          direction,
  output logic signed [31:0]  speed_q16,
  input  wire                 cfg_valid,
  output logic                cfg_ready,
  input  wire  [1:0]          cfg_index,
  input  wire  [15:0]         cfg_data
);

  qsm_pkg::qsm_cfg_t      cfg;
  logic                   accept;
  logic                   closes;
  logic                   busy;
  logic                   start;
  logic [COUNT_WIDTH-1:0] snap;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ppr <= qsm_pkg::PPR_RESET;
      cfg.win <= qsm_pkg::WIN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        qsm_pkg::REG_PPR:    cfg.ppr <= cfg_data;
        qsm_pkg::REG_WINDOW: cfg.win <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // hold a closing sample while the divider is occupied
  assign in_stall = busy && ms_tick && closes;
  assign accept   = in_valid && !in_stall;
  assign start    = accept && closes;

  qsm_counter #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_counter (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .pin_a   (pin_a),
    .pin_b   (pin_b),
    .ms_tick (ms_tick),
    .cfg     (cfg),
    .closes  (closes),
    .snap    (snap)
  );

  qsm_divider #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_divider (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .snap       (snap),
    .cfg        (cfg),
    .out_stall  (out_stall),
    .busy       (busy),
    .out_valid  (out_valid),
    .edge_count (edge_count),
    .direction  (direction),
    .speed_q16  (speed_q16)
  );

  // a window snapshot never lands on a busy divider
  a_start_idle: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("window snapshot taken while divider busy");

  // divider picks up every snapshot
  a_start_busy: assert property (@(posedge clk) disable iff (rst) start |=> busy)
    else $error("divider did not start on window close");

  // zero direction exactly when the count is zero
  a_dir_count: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((direction == qsm_pkg::DIR_NONE) == (edge_count == 24'sd0)))
    else $error("direction disagrees with edge count");

  // clockwise results never carry a negative speed
  a_dir_speed: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (direction == qsm_pkg::DIR_CW)) |-> !speed_q16[31])
    else $error("clockwise result with negative speed");

endmodule

`default_nettype wire
